// ===== rtl/lpse_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpse_pkg
// Shared types, constants and the class cost table for the line pattern
// size estimator.
// ----------------------------------------------------------------------------
package lpse_pkg;

  // line geometry
  localparam int WORDS_PER_LINE = 8;
  localparam int POS_W          = 4;
  localparam int WORD_W         = 32;
  localparam int SE_W           = 9;
  localparam int COST_W         = 6;
  localparam int TOTAL_W        = 10;
  localparam int CLASS_W        = 4;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(WORDS_PER_LINE - 1);

  // pattern classes in priority order
  typedef enum logic [CLASS_W-1:0] {
    CLS_ZERO       = 4'd0,
    CLS_SAME       = 4'd1,
    CLS_LOW16_ZERO = 4'd2,
    CLS_HI16_ZERO  = 4'd3,
    CLS_DELTA16    = 4'd4,
    CLS_LOW8_ZERO  = 4'd5,
    CLS_HI8_ZERO   = 4'd6,
    CLS_SE3_UP     = 4'd7,
    CLS_SE3_DOWN   = 4'd8,
    CLS_SE2_UP     = 4'd9,
    CLS_SE2_DOWN   = 4'd10,
    CLS_SE4_UP     = 4'd11,
    CLS_SE4_DOWN   = 4'd12,
    CLS_RAW        = 4'd13
  } class_t;

  // per-line status from the line tracker
  typedef struct packed {
    logic                has_prev;
    logic                last;
    logic [TOTAL_W-1:0]  total;
  } line_stat_t;

  // prefix plus data bits for each class
  function automatic logic [COST_W-1:0] class_cost(input logic [CLASS_W-1:0] cls);
    logic [COST_W-1:0] c;
    case (cls)
      CLS_ZERO, CLS_SAME:                          c = 6'd5;
      CLS_LOW16_ZERO, CLS_HI16_ZERO, CLS_DELTA16:  c = 6'd21;
      CLS_LOW8_ZERO, CLS_HI8_ZERO:                 c = 6'd28;
      CLS_SE3_UP, CLS_SE3_DOWN:                    c = 6'd29;
      CLS_SE2_UP, CLS_SE2_DOWN,
      CLS_SE4_UP, CLS_SE4_DOWN:                    c = 6'd31;
      default:                                     c = 6'd35;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/lpse_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpse_in_if / lpse_out_if
// Valid/ready channels for input words and per-word size results.
// ----------------------------------------------------------------------------
interface lpse_in_if;
  import lpse_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] data_word;

  modport source (output valid, output data_word, input ready);
  modport sink   (input valid, input data_word, output ready);
endinterface

interface lpse_out_if;
  import lpse_pkg::*;
  logic               valid;
  logic               ready;
  logic [CLASS_W-1:0] pattern_class;
  logic [COST_W-1:0]  code_bits;
  logic [TOTAL_W-1:0] line_bits;
  logic               last_of_line;

  modport source (output valid, output pattern_class, output code_bits,
                  output line_bits, output last_of_line, input ready);
  modport sink   (input valid, input pattern_class, input code_bits,
                  input line_bits, input last_of_line, output ready);
endinterface

// ===== rtl/lpse_classify.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpse_classify
// Priority pattern match of one word against the previous word of the line.
// ----------------------------------------------------------------------------
module lpse_classify
  import lpse_pkg::*;
(
  input  logic [WORD_W-1:0]  word,
  input  logic [WORD_W-1:0]  prev,
  input  logic               has_prev,
  output logic [CLASS_W-1:0] cls,
  output logic [COST_W-1:0]  cost
);

  logic [SE_W-1:0] se_w;
  logic [SE_W-1:0] se_p;
  logic [SE_W-1:0] diff_up;
  logic [SE_W-1:0] diff_dn;
  logic            ge;
  logic            le;
  logic [15:0]     xw;

  // sign+exponent fields and their distances
  assign se_w    = {word[31], word[30:23]};
  assign se_p    = {prev[31], prev[30:23]};
  assign ge      = se_w >= se_p;
  assign le      = se_w <= se_p;
  assign diff_up = se_w - se_p;
  assign diff_dn = se_p - se_w;
  assign xw      = word[31:16] ^ prev[31:16];

  // first match wins
  always_comb begin
    class_t c;
    c = CLS_RAW;
    if (word == '0) begin
      c = CLS_ZERO;
    end else if (has_prev && word == prev) begin
      c = CLS_SAME;
    end else if (word[15:0] == '0) begin
      c = CLS_LOW16_ZERO;
    end else if (word[31:16] == '0) begin
      c = CLS_HI16_ZERO;
    end else if (has_prev && xw == '0) begin
      c = CLS_DELTA16;
    end else if (word[7:0] == '0) begin
      c = CLS_LOW8_ZERO;
    end else if (word[31:24] == '0) begin
      c = CLS_HI8_ZERO;
    end else if (has_prev) begin
      if (ge && diff_up < 9'd8) begin
        c = CLS_SE3_UP;
      end else if (le && diff_dn < 9'd8) begin
        c = CLS_SE3_DOWN;
      end else if (ge && diff_up < 9'd4) begin
        c = CLS_SE2_UP;
      end else if (le && diff_dn < 9'd4) begin
        c = CLS_SE2_DOWN;
      end else if (ge && diff_up < 9'd16) begin
        c = CLS_SE4_UP;
      end else if (le && diff_dn < 9'd16) begin
        c = CLS_SE4_DOWN;
      end
    end
    cls = c;
  end

  assign cost = class_cost(cls);

endmodule

// ===== rtl/lpse_line_track.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpse_line_track
// Previous word, position in the line and running bit total.
// ----------------------------------------------------------------------------
module lpse_line_track
  import lpse_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic [WORD_W-1:0] word,
  input  logic [COST_W-1:0] cost,
  output logic [WORD_W-1:0] prev_word,
  output line_stat_t        stat
);

  logic [POS_W-1:0]   word_pos;
  logic [TOTAL_W-1:0] bit_total;
  logic [TOTAL_W-1:0] bit_total_next;

  // running sum including the current word
  assign bit_total_next = bit_total + TOTAL_W'(cost);

  assign stat.has_prev = word_pos != '0;
  assign stat.last     = word_pos >= LAST_POS;
  assign stat.total    = bit_total_next;

  // state update once per word
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_word <= '0;
      word_pos  <= '0;
      bit_total <= '0;
    end else if (advance) begin
      prev_word <= word;
      if (stat.last) begin
        word_pos  <= '0;
        bit_total <= '0;
      end else begin
        word_pos  <= word_pos + 1'b1;
        bit_total <= bit_total_next;
      end
    end
  end

  // position stays inside the line
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    word_pos < POS_W'(WORDS_PER_LINE))
    else $error("word position beyond line");

  // line end restarts position and total
  a_line_restart: assert property (@(posedge clk) disable iff (rst)
    advance && stat.last |=> word_pos == '0 && bit_total == '0)
    else $error("line did not restart");

  // mid-line word steps position by one
  a_pos_step: assert property (@(posedge clk) disable iff (rst)
    advance && !stat.last |=> word_pos == $past(word_pos) + 1'b1)
    else $error("position did not advance");

endmodule

// ===== rtl/line_pattern_size_estimator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_pattern_size_estimator
// Classifies each 32-bit word of a cache line into a frequent pattern class
// and keeps a running compressed bit count for the line.
//
//   channel   dir   payload
//   in_ch     in    data_word
//   out_ch    out   pattern_class, code_bits, line_bits, last_of_line
//
// One word per cycle sustained while the sink keeps ready high; an input beat
// passes the input register, then the result register after the classifier.
// The input register can load while the result register holds, so a stalled
// sink with a full result register still lets it fill once before ready drops.
// Synchronous reset clears valid bits, previous word, position and total.
// Line state advances when a word moves from the input into the result
// register, so back-to-back words see each other.
// ----------------------------------------------------------------------------
module line_pattern_size_estimator
  import lpse_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  lpse_in_if.sink    in_ch,
  lpse_out_if.source out_ch
);

  logic               s1_valid;
  logic [WORD_W-1:0]  s1_word;
  logic               s1_go;
  logic [WORD_W-1:0]  prev_word;
  line_stat_t         stat;
  logic [CLASS_W-1:0] cls;
  logic [COST_W-1:0]  cost;

  // stage 1 moves when the result register is free or being drained
  assign s1_go       = s1_valid && (!out_ch.valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || s1_go;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_word <= in_ch.data_word;
    end
  end

  lpse_line_track u_track (
    .clk       (clk),
    .rst       (rst),
    .advance   (s1_go),
    .word      (s1_word),
    .cost      (cost),
    .prev_word (prev_word),
    .stat      (stat)
  );

  lpse_classify u_classify (
    .word     (s1_word),
    .prev     (prev_word),
    .has_prev (stat.has_prev),
    .cls      (cls),
    .cost     (cost)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (s1_go) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_ch.pattern_class <= cls;
      out_ch.code_bits     <= cost;
      out_ch.line_bits     <= stat.total;
      out_ch.last_of_line  <= stat.last;
    end
  end

  // both stages full and sink stalled means no new beat
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("input accepted while pipeline full");

  // charged bits match the class
  a_cost_match: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.code_bits == class_cost(out_ch.pattern_class))
    else $error("cost does not match class");

  // total always covers this word
  a_total_cover: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.line_bits >= TOTAL_W'(out_ch.code_bits))
    else $error("line total below word cost");

endmodule
